/* rtl/psd3_pkg.sv */
// Shared types, widths and codes for the point-to-segment distance block.
package psd3_pkg;

    localparam int COORD_W     = 32;             // Q15.16 coordinate
    localparam int DIFF_W      = 33;             // exact coordinate difference
    localparam int PROD_W      = 66;             // exact product of two differences
    localparam int DOT_W       = 67;             // signed dot product
    localparam int EXT_W       = 68;             // dot product with headroom
    localparam int SQ_W        = 66;             // unsigned squared length
    localparam int HALF_W      = 33;             // half of a squared length
    localparam int WIDE_W      = 132;            // squared cross length, Q.64
    localparam int DIST_W      = 33;             // Q17.16 distance
    localparam int REM_W       = 36;             // root remainder
    localparam int DIV_STEPS   = 66;             // quotient bits
    localparam int SQRT_STEPS  = 33;             // root bits
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = 3'd5;

    localparam logic [COORD_W-1:0] RST_END_X = 32'h0001_0000;   // 1.0

    typedef enum logic [1:0] {
        RG_START = 2'd0,
        RG_END   = 2'd1,
        RG_MID   = 2'd2
    } t_region;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        t_region           region;
    } t_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } t_seg;

    // Classified item handed from front to back.
    typedef struct packed {
        t_region         region;
        logic [SQ_W-1:0] s;     // squared endpoint distance
        logic [SQ_W-1:0] d;     // dot(ab,av), positive for interior
        logic [SQ_W-1:0] v;     // |av|^2
        logic [SQ_W-1:0] a;     // |ab|^2
    } t_qent;

endpackage

/* rtl/psd3_front.sv */
// Front pipeline: differences, dot products, squared lengths and region classification.
module psd3_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  psd3_pkg::t_in   i_data,
    input  psd3_pkg::t_seg  i_seg,
    output logic            o_valid,
    output psd3_pkg::t_qent o_ent
);

    localparam int DW = psd3_pkg::DIFF_W;
    localparam int PW = psd3_pkg::PROD_W;
    localparam int SW = psd3_pkg::SQ_W;
    localparam int OW = psd3_pkg::DOT_W;
    localparam int EW = psd3_pkg::EXT_W;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    psd3_pkg::t_in          r_pt;
    logic signed [DW-1:0]   r_av [3];
    logic signed [DW-1:0]   r_ab [3];
    logic signed [PW-1:0]   r_pd [3];
    logic signed [PW-1:0]   r_pv [3];
    logic signed [PW-1:0]   r_pa [3];
    logic signed [OW-1:0]   r_dot;
    logic [SW-1:0]          r_vv;
    logic [SW-1:0]          r_aa;
    psd3_pkg::t_qent        r_ent;

    logic signed [DW-1:0]   n_av [3];
    logic signed [DW-1:0]   n_ab [3];
    logic signed [EW-1:0]   n_d2;
    logic signed [EW-1:0]   n_w;
    logic                   n_dot_pos;
    psd3_pkg::t_qent        n_ent;

    always_comb begin
        n_av[0] = DW'(r_pt.point_x) - DW'(i_seg.start_x);
        n_av[1] = DW'(r_pt.point_y) - DW'(i_seg.start_y);
        n_av[2] = DW'(r_pt.point_z) - DW'(i_seg.start_z);
        n_ab[0] = DW'(i_seg.end_x) - DW'(i_seg.start_x);
        n_ab[1] = DW'(i_seg.end_y) - DW'(i_seg.start_y);
        n_ab[2] = DW'(i_seg.end_z) - DW'(i_seg.start_z);
    end

    // dot(ab,bv) = dot(ab,av) - |ab|^2 ; |bv|^2 = |av|^2 - 2 dot(ab,av) + |ab|^2
    always_comb begin
        n_dot_pos = !r_dot[OW-1] && (r_dot != '0);
        n_d2      = EW'(r_dot) - $signed({2'b00, r_aa});
        n_w       = $signed({2'b00, r_vv}) - (EW'(r_dot) <<< 1) + $signed({2'b00, r_aa});
        n_ent.d   = r_dot[SW-1:0];
        n_ent.v   = r_vv;
        n_ent.a   = r_aa;
        if (!n_dot_pos) begin
            n_ent.region = psd3_pkg::RG_START;
            n_ent.s      = r_vv;
        end else if (!n_d2[EW-1]) begin
            n_ent.region = psd3_pkg::RG_END;
            n_ent.s      = n_w[SW-1:0];
        end else begin
            n_ent.region = psd3_pkg::RG_MID;
            n_ent.s      = r_vv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= i_data;
            for (int i = 0; i < 3; i++) begin
                r_av[i] <= n_av[i];
                r_ab[i] <= n_ab[i];
                r_pd[i] <= r_ab[i] * r_av[i];
                r_pv[i] <= r_av[i] * r_av[i];
                r_pa[i] <= r_ab[i] * r_ab[i];
            end
            r_dot <= OW'(r_pd[0]) + OW'(r_pd[1]) + OW'(r_pd[2]);
            r_vv  <= $unsigned(r_pv[0]) + $unsigned(r_pv[1]) + $unsigned(r_pv[2]);
            r_aa  <= $unsigned(r_pa[0]) + $unsigned(r_pa[1]) + $unsigned(r_pa[2]);
            r_ent <= n_ent;
        end
    end

    assign o_valid = r_v5;
    assign o_ent   = r_ent;

endmodule

/* rtl/psd3_queue.sv */
// Small FIFO between the front and back pipelines.
module psd3_queue #(
    parameter int DEPTH = psd3_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psd3_pkg::t_qent i_ent,
    input  logic            i_pop,
    output psd3_pkg::t_qent o_ent,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psd3_pkg::t_qent  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    assign o_ent   = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

/* rtl/psd3_back.sv */
// Back multiply stages: squared cross length as |ab|^2|av|^2 - dot^2, divider operands.
module psd3_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  psd3_pkg::t_qent               i_ent,
    output logic                          o_valid,
    output logic [psd3_pkg::WIDE_W-1:0]   o_num,
    output logic [psd3_pkg::SQ_W-1:0]     o_den,
    output psd3_pkg::t_region             o_region
);

    localparam int HW = psd3_pkg::HALF_W;
    localparam int PW = psd3_pkg::PROD_W;
    localparam int SW = psd3_pkg::SQ_W;
    localparam int WW = psd3_pkg::WIDE_W;

    logic r_v1, r_v2, r_v3;

    psd3_pkg::t_qent   r_ent;
    logic [PW-1:0]     r_avhh, r_avhl, r_avlh, r_avll;
    logic [PW-1:0]     r_ddhh, r_ddhl, r_ddll;
    logic [SW-1:0]     r_s2, r_a2, r_s3, r_a3;
    psd3_pkg::t_region r_rg2, r_rg3;
    logic [WW-1:0]     r_av, r_dd;

    logic [HW-1:0] n_ah, n_al, n_vh, n_vl, n_dh, n_dl;

    assign n_ah = r_ent.a[SW-1:HW];
    assign n_al = r_ent.a[HW-1:0];
    assign n_vh = r_ent.v[SW-1:HW];
    assign n_vl = r_ent.v[HW-1:0];
    assign n_dh = r_ent.d[SW-1:HW];
    assign n_dl = r_ent.d[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ent  <= i_ent;
            // partial products, 33x33 each
            r_avhh <= n_ah * n_vh;
            r_avhl <= n_ah * n_vl;
            r_avlh <= n_al * n_vh;
            r_avll <= n_al * n_vl;
            r_ddhh <= n_dh * n_dh;
            r_ddhl <= n_dh * n_dl;
            r_ddll <= n_dl * n_dl;
            r_s2   <= r_ent.s;
            r_a2   <= r_ent.a;
            r_rg2  <= r_ent.region;
            r_av   <= {r_avhh, {PW{1'b0}}} + ((WW'(r_avhl) + WW'(r_avlh)) << HW)
                      + WW'(r_avll);
            r_dd   <= {r_ddhh, {PW{1'b0}}} + (WW'(r_ddhl) << (HW + 1)) + WW'(r_ddll);
            r_s3   <= r_s2;
            r_a3   <= r_a2;
            r_rg3  <= r_rg2;
        end
    end

    // endpoint cases go through the divider as s / 1
    always_comb begin
        if (r_rg3 == psd3_pkg::RG_MID) begin
            o_num = r_av - r_dd;
            o_den = r_a3;
        end else begin
            o_num = WW'(r_s3);
            o_den = SW'(1);
        end
    end

    assign o_valid  = r_v3;
    assign o_region = r_rg3;

endmodule

/* rtl/psd3_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module psd3_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [psd3_pkg::WIDE_W-1:0]   i_num,
    input  logic [psd3_pkg::SQ_W-1:0]     i_den,
    input  psd3_pkg::t_region             i_region,
    output logic                          o_valid,
    output logic [psd3_pkg::SQ_W-1:0]     o_quo,
    output psd3_pkg::t_region             o_region
);

    localparam int N  = psd3_pkg::DIV_STEPS;
    localparam int SW = psd3_pkg::SQ_W;
    localparam int WW = psd3_pkg::WIDE_W;

    // upper half remainder, lower half dividend bits then quotient bits
    logic [WW-1:0]     r_x   [N+1];
    logic [SW-1:0]     r_den [N+1];
    psd3_pkg::t_region r_rg  [N+1];
    logic [N:0]        r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_num;
            r_den[0] <= i_den;
            r_rg[0]  <= i_region;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [SW:0] n_t;
        logic [SW:0] n_diff;

        assign n_t    = r_x[k][WW-1:SW-1];
        assign n_diff = n_t - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!n_diff[SW]) begin
                    r_x[k+1] <= {n_diff[SW-1:0], r_x[k][SW-2:0], 1'b1};
                end else begin
                    r_x[k+1] <= {n_t[SW-1:0], r_x[k][SW-2:0], 1'b0};
                end
                r_den[k+1] <= r_den[k];
                r_rg[k+1]  <= r_rg[k];
            end
        end
    end

    assign o_valid  = r_v[N];
    assign o_quo    = r_x[N][SW-1:0];
    assign o_region = r_rg[N];

endmodule

/* rtl/psd3_sqrt.sv */
// Pipelined integer square root, one root bit per stage; last stage is the output register.
module psd3_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [psd3_pkg::SQ_W-1:0]     i_rad,
    input  psd3_pkg::t_region             i_region,
    output logic                          o_valid,
    output psd3_pkg::t_out                o_data
);

    localparam int N  = psd3_pkg::SQRT_STEPS;
    localparam int SW = psd3_pkg::SQ_W;
    localparam int RW = psd3_pkg::REM_W;
    localparam int DW = psd3_pkg::DIST_W;

    logic [RW-1:0]     r_rem  [N+1];
    logic [DW-1:0]     r_root [N+1];
    logic [SW-1:0]     r_rad  [N+1];
    psd3_pkg::t_region r_rg   [N+1];
    logic [N:0]        r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_rad;
            r_rg[0]   <= i_region;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0] n_rem2;
        logic [RW-1:0] n_trial;

        // remainder is at most 2*root, so its top two bits are free
        assign n_rem2  = {r_rem[k][RW-3:0], r_rad[k][SW-1:SW-2]};
        assign n_trial = {1'b0, r_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_rem2 >= n_trial) begin
                    r_rem[k+1]  <= n_rem2 - n_trial;
                    r_root[k+1] <= {r_root[k][DW-2:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= n_rem2;
                    r_root[k+1] <= {r_root[k][DW-2:0], 1'b0};
                end
                r_rad[k+1] <= {r_rad[k][SW-3:0], 2'b00};
                r_rg[k+1]  <= r_rg[k];
            end
        end
    end

    assign o_valid         = r_v[N];
    assign o_data.distance = r_root[N];
    assign o_data.region   = r_rg[N];

endmodule

/* rtl/point_segment_distance_3d_core.sv */
// Top level: distance from a 3D point to a configured segment, with region code.
//
// Input channel (i_valid / o_ready, payload i_data): one query point per beat,
// signed Q15.16 per axis. Output channel (o_valid / i_ready, payload o_data):
// one result per beat, distance in unsigned Q17.16 (truncated) and the region
// of the nearest feature (start point, end point or segment interior).
// Config channel (i_cfg_valid / o_cfg_ready): i_cfg_index selects start x,y,z
// (0..2) or end x,y,z (3..5); other indexes are dropped. o_cfg_ready is always
// high. Write only while no result is outstanding.
//
// Throughput: one point per cycle while the output is not stalled and the
// queue has room. The divider has 66 stages and the square root 33. A 5-stage
// front classifies each point and pushes it into a small queue; the back
// pulls from it through the multiply, divide and root stages. When o_valid is
// high and i_ready is low the whole back holds; the queue then fills and
// o_ready drops once it is full, so no beat is lost.
//
// Reset (synchronous, active low) empties every stage and the queue and sets
// the segment to start (0,0,0), end (1.0,0,0).
module point_segment_distance_3d_core #(
    parameter int QUEUE_DEPTH = psd3_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  psd3_pkg::t_in                    i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output psd3_pkg::t_out                   o_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [psd3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psd3_pkg::COORD_W-1:0]     i_cfg_data
);

    psd3_pkg::t_seg    r_seg;

    logic              front_en;
    logic              back_en;
    logic              f_valid;
    psd3_pkg::t_qent   f_ent;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    psd3_pkg::t_qent   q_ent;
    logic              b_valid;
    logic [psd3_pkg::WIDE_W-1:0] b_num;
    logic [psd3_pkg::SQ_W-1:0]   b_den;
    psd3_pkg::t_region b_region;
    logic              d_valid;
    logic [psd3_pkg::SQ_W-1:0]   d_quo;
    psd3_pkg::t_region d_region;

    // segment registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.start_x <= '0;
            r_seg.start_y <= '0;
            r_seg.start_z <= '0;
            r_seg.end_x   <= psd3_pkg::RST_END_X;
            r_seg.end_y   <= '0;
            r_seg.end_z   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psd3_pkg::CFG_START_X: r_seg.start_x <= i_cfg_data;
                psd3_pkg::CFG_START_Y: r_seg.start_y <= i_cfg_data;
                psd3_pkg::CFG_START_Z: r_seg.start_z <= i_cfg_data;
                psd3_pkg::CFG_END_X:   r_seg.end_x   <= i_cfg_data;
                psd3_pkg::CFG_END_Y:   r_seg.end_y   <= i_cfg_data;
                psd3_pkg::CFG_END_Z:   r_seg.end_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // front moves whenever the queue has room; back moves unless the output is stuck
    assign front_en = !q_full;
    assign o_ready  = front_en;
    assign back_en  = !o_valid || i_ready;
    assign q_push   = f_valid && front_en;
    assign q_pop    = back_en && !q_empty;

    psd3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_seg   (r_seg),
        .o_valid (f_valid),
        .o_ent   (f_ent)
    );

    psd3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (f_ent),
        .i_pop   (q_pop),
        .o_ent   (q_ent),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    psd3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (back_en),
        .i_valid  (!q_empty),
        .i_ent    (q_ent),
        .o_valid  (b_valid),
        .o_num    (b_num),
        .o_den    (b_den),
        .o_region (b_region)
    );

    psd3_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (back_en),
        .i_valid  (b_valid),
        .i_num    (b_num),
        .i_den    (b_den),
        .i_region (b_region),
        .o_valid  (d_valid),
        .o_quo    (d_quo),
        .o_region (d_region)
    );

    psd3_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (back_en),
        .i_valid  (d_valid),
        .i_rad    (d_quo),
        .i_region (d_region),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

endmodule

/* rtl/psd3_checker.sv */
// Port-level checks for the distance core, bound to the top level.
module psd3_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input psd3_pkg::t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready right after reset");

    a_rst_drain: assert property (@(posedge i_clk)
        !i_rst_n |-> ##2 !o_valid)
        else $error("output valid too soon after reset");

endmodule

bind point_segment_distance_3d_core psd3_checker u_psd3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

/* tb/sv/tb_point_segment_distance_3d_core.sv */
// Testbench for point_segment_distance_3d_core: exact-arithmetic distance predictor and checker.
module tb_point_segment_distance_3d_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WN       = 200;   // wide enough for every exact intermediate
    localparam int SETTLE   = 150;   // longer than the pipeline latency
    localparam int IDLE_PCT = 36;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    psd3_pkg::t_in                   i_data = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    psd3_pkg::t_out                  o_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [psd3_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [psd3_pkg::COORD_W-1:0]    i_cfg_data = '0;

    point_segment_distance_3d_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the segment registers: index 0..2 start, 3..5 end.
    logic signed [psd3_pkg::COORD_W-1:0] seg_reg [6];
    psd3_pkg::t_out pending_results [$];
    int   fail_count = 0;
    bit   calm = 1'b0;   // no idling on either side while set

    // ---------------------------------------------------------------
    // Distance predictor, exact integer arithmetic
    // ---------------------------------------------------------------
    function automatic logic [35:0] floor_root(logic [WN-1:0] n);
        logic [35:0]   r;
        logic [WN-1:0] c;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            c = WN'(r | (36'd1 << b));
            if (c * c <= n) r = r | (36'd1 << b);
        end
        return r;
    endfunction

    function automatic psd3_pkg::t_out predict_distance(psd3_pkg::t_in pt);
        logic signed [WN-1:0] ab [3];
        logic signed [WN-1:0] av [3];
        logic signed [WN-1:0] bv [3];
        logic signed [WN-1:0] p  [3];
        logic signed [WN-1:0] d_start, d_end, cx, cy, cz;
        logic [WN-1:0]        cross_sq, ab_sq, len_sq;
        logic [35:0]          root;
        psd3_pkg::t_out       res;
        p[0] = pt.point_x;
        p[1] = pt.point_y;
        p[2] = pt.point_z;
        for (int i = 0; i < 3; i++) begin
            ab[i] = WN'(seg_reg[i + 3]) - WN'(seg_reg[i]);
            av[i] = p[i] - WN'(seg_reg[i]);
            bv[i] = p[i] - WN'(seg_reg[i + 3]);
        end
        d_start = ab[0] * av[0] + ab[1] * av[1] + ab[2] * av[2];
        d_end   = ab[0] * bv[0] + ab[1] * bv[1] + ab[2] * bv[2];
        if (d_start <= 0) begin
            // nearest to start; also covers a zero-length segment
            len_sq = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
            res.region = psd3_pkg::RG_START;
            root = floor_root(len_sq);
        end else if (d_end >= 0) begin
            len_sq = bv[0] * bv[0] + bv[1] * bv[1] + bv[2] * bv[2];
            res.region = psd3_pkg::RG_END;
            root = floor_root(len_sq);
        end else begin
            cx = ab[1] * av[2] - ab[2] * av[1];
            cy = ab[2] * av[0] - ab[0] * av[2];
            cz = ab[0] * av[1] - ab[1] * av[0];
            cross_sq = cx * cx + cy * cy + cz * cz;
            ab_sq    = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
            res.region = psd3_pkg::RG_MID;
            root = floor_root(cross_sq / ab_sq);
        end
        res.distance = root[psd3_pkg::DIST_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // One point beat; the expectation is queued when the beat is taken.
    task automatic send_point(psd3_pkg::t_in pt);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= pt;
        do @(posedge i_clk); while (!o_ready);
        pending_results.insert(pending_results.size(), predict_distance(pt));
    endtask

    task automatic park_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every result, then let the pipeline go quiet.
    task automatic drain();
        park_input();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [psd3_pkg::CFG_IDX_W-1:0] idx,
                             logic [psd3_pkg::COORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx <= psd3_pkg::CFG_END_Z) seg_reg[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic set_segment(logic [psd3_pkg::COORD_W-1:0] sx,
                               logic [psd3_pkg::COORD_W-1:0] sy,
                               logic [psd3_pkg::COORD_W-1:0] sz,
                               logic [psd3_pkg::COORD_W-1:0] ex,
                               logic [psd3_pkg::COORD_W-1:0] ey,
                               logic [psd3_pkg::COORD_W-1:0] ez);
        drain();
        write_reg(psd3_pkg::CFG_START_X, sx);
        write_reg(psd3_pkg::CFG_START_Y, sy);
        write_reg(psd3_pkg::CFG_START_Z, sz);
        write_reg(psd3_pkg::CFG_END_X, ex);
        write_reg(psd3_pkg::CFG_END_Y, ey);
        write_reg(psd3_pkg::CFG_END_Z, ez);
    endtask

    function automatic logic [psd3_pkg::COORD_W-1:0] near_coord(int span);
        return psd3_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic psd3_pkg::t_in make_point(logic [psd3_pkg::COORD_W-1:0] x,
                                                 logic [psd3_pkg::COORD_W-1:0] y,
                                                 logic [psd3_pkg::COORD_W-1:0] z);
        psd3_pkg::t_in pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        return pt;
    endfunction

    // ---------------------------------------------------------------
    // Result checker and output-side stall
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        psd3_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_data), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_data.distance !== want.distance)
                    report_mismatch("distance", 64'(o_data.distance), 64'(want.distance));
                if (o_data.region !== want.region)
                    report_mismatch("region", 64'(o_data.region), 64'(want.region));
            end
        end
        if (!i_rst_n) i_ready <= 1'b0;
        else          i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset segment runs (0,0,0) to (1.0,0,0): hit all three regions.
    task automatic test_reset_segment();
        send_point(make_point(32'hFFFF_0000, 32'h0, 32'h0));        // before start
        send_point(make_point(32'h0, 32'h0, 32'h0));                // on start
        send_point(make_point(32'h0000_8000, 32'h0003_0000, 32'h0)); // interior
        send_point(make_point(32'h0001_0000, 32'h0, 32'h0));        // on end
        send_point(make_point(32'h0002_0000, 32'h0, 32'h0001_0000)); // past end
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point(make_point(32'h0000_4000, 32'h8000_0000, 32'h7FFF_FFFF));
    endtask

    // Segment spanning the full coordinate range, far points included.
    task automatic test_extreme_segment();
        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        send_point(make_point(32'h0, 32'h0, 32'h1234_5678));
        // maximum distance: segment along an edge of the cube, points on the opposite edge
        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    endtask

    // Start equals end: always start region, no division by the zero-length |ab|^2.
    task automatic test_zero_length();
        set_segment(32'h0003_0000, 32'hFFFE_0000, 32'h0000_0001,
                    32'h0003_0000, 32'hFFFE_0000, 32'h0000_0001);
        send_point(make_point(32'h0003_0000, 32'hFFFE_0000, 32'h0000_0001));
        send_point(make_point(32'h0, 32'h0, 32'h0));
        send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    endtask

    // Writes to indexes six and seven must leave the segment alone.
    task automatic test_unused_index();
        set_segment(32'h0, 32'h0, 32'h0, 32'h0, 32'h0004_0000, 32'h0);
        write_reg(psd3_pkg::CFG_IDX_W'(6), 32'h7FFF_FFFF);
        write_reg(psd3_pkg::CFG_IDX_W'(7), 32'h8000_0000);
        send_point(make_point(32'h0001_0000, 32'h0002_0000, 32'h0));
        send_point(make_point(32'h0, 32'h0005_0000, 32'h0));
        send_point(make_point(32'h0, 32'hFFFF_0000, 32'h0));
    endtask

    // Random segments; most points close to the segment so every region shows up,
    // the rest anywhere in the coordinate space.
    task automatic test_random_points(int rounds, int per_round);
        int span;
        for (int r = 0; r < rounds; r++) begin
            span = (r % 4 == 3) ? 32'h3FFF_FFFF : (1 << $urandom_range(4, 24));
            set_segment(near_coord(span), near_coord(span), near_coord(span),
                        near_coord(span), near_coord(span), near_coord(span));
            calm = (r == 1);   // one whole round with no idling
            if (r == rounds / 2) begin
                // long pause until the pipeline has emptied
                drain();
            end
            for (int k = 0; k < per_round; k++) begin
                if ($urandom_range(0, 99) < 80)
                    send_point(make_point(near_coord(span * 2), near_coord(span * 2),
                                          near_coord(span * 2)));
                else
                    send_point(make_point($urandom, $urandom, $urandom));
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        seg_reg[0] = '0;
        seg_reg[1] = '0;
        seg_reg[2] = '0;
        seg_reg[3] = psd3_pkg::RST_END_X;
        seg_reg[4] = '0;
        seg_reg[5] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_segment();
        test_extreme_segment();
        test_zero_length();
        test_unused_index();
        test_random_points(10, 40);

        drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/psd3_pkg.sv
rtl/psd3_front.sv
rtl/psd3_queue.sv
rtl/psd3_back.sv
rtl/psd3_div.sv
rtl/psd3_sqrt.sv
rtl/point_segment_distance_3d_core.sv
rtl/psd3_checker.sv
tb/sv/tb_point_segment_distance_3d_core.sv
